>>> design/ppd_pkg.sv
// Shared types and widths for the point-to-plane distance pipeline.
// No dependencies; every other design file refers to it by scoped names.
package ppd_pkg;

  localparam int CW  = 32;              // coordinate width
  localparam int DW  = CW + 1;          // coordinate difference width
  localparam int PW  = 2 * DW;          // cross product term width
  localparam int NW  = PW + 1;          // normal component width
  localparam int QW  = CW + 1;          // quotient bits incl. overflow bit
  localparam int NS  = QW;              // root stages, one quotient bit each
  localparam int LB  = 26;              // multiplier limb width
  localparam int NL  = 4;               // limbs per multiplier operand
  localparam int MW  = LB * NL;         // multiplier operand width
  localparam int RW  = 2 * MW;          // product and remainder width
  localparam int ML  = 1 + $clog2(NL * NL);  // multiplier latency

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic signed [CW-1:0] third_z;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
  } in_word_t;

  typedef struct packed {
    logic [CW-1:0] distance;
    logic          degenerate;
    logic          saturated;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic degen;
  } ctl_t;

endpackage

>>> design/ppd_in_if.sv
// Input channel: valid/ready handshake carrying one query word.
// Depends on ppd_pkg for the payload type.
interface ppd_in_if;
  logic               valid;
  logic               ready;
  ppd_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/ppd_out_if.sv
// Result channel: valid/ready handshake carrying one distance word.
// Depends on ppd_pkg for the payload type.
interface ppd_out_if;
  logic                valid;
  logic                ready;
  ppd_pkg::out_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/ppd_mul.sv
// Pipelined unsigned multiplier: limb partial products, then a registered adder tree.
// Depends on ppd_pkg for operand and limb widths.
module ppd_mul (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ppd_pkg::MW-1:0] a,
  input  logic [ppd_pkg::MW-1:0] b,
  output logic [ppd_pkg::RW-1:0] p
);

  localparam int NPP = ppd_pkg::NL * ppd_pkg::NL;

  logic [2*ppd_pkg::LB-1:0] pp_r [NPP];
  logic [ppd_pkg::RW-1:0]   lf   [NPP];
  logic [ppd_pkg::RW-1:0]   nd_r [1:NPP-1];

  genvar i, j, k;
  for (i = 0; i < ppd_pkg::NL; i++) begin : g_row
    for (j = 0; j < ppd_pkg::NL; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          pp_r[i*ppd_pkg::NL+j] <= a[i*ppd_pkg::LB +: ppd_pkg::LB] *
                                   b[j*ppd_pkg::LB +: ppd_pkg::LB];
        end
      end
      assign lf[i*ppd_pkg::NL+j] =
        ppd_pkg::RW'(pp_r[i*ppd_pkg::NL+j]) << (ppd_pkg::LB * (i + j));
    end
  end

  // heap-ordered tree: node k sums nodes 2k and 2k+1, leaves past the last node
  for (k = 1; k < NPP; k++) begin : g_node
    if (2 * k >= NPP) begin : g_leaf
      always_ff @(posedge clk) begin
        if (en) begin
          nd_r[k] <= lf[2*k-NPP] + lf[2*k+1-NPP];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (en) begin
          nd_r[k] <= nd_r[2*k] + nd_r[2*k+1];
        end
      end
    end
  end

  assign p = nd_r[1];

endmodule

>>> design/ppd_root.sv
// Restoring quotient stages: one bit of floor(|a.n| / |n|) per register stage.
// Depends on ppd_pkg for widths and the control struct.
module ppd_root (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  ppd_pkg::ctl_t          ctl_in,
  input  logic [ppd_pkg::RW-1:0] rem_in,
  input  logic [ppd_pkg::RW-1:0] nn_in,
  input  logic [ppd_pkg::RW-1:0] nn3_in,
  output logic                   out_vld,
  output ppd_pkg::out_word_t     out_word
);

  localparam int NS = ppd_pkg::NS;
  localparam int RW = ppd_pkg::RW;
  localparam int CW = ppd_pkg::CW;

  // rem: dot^2 - q^2*nn; x: (q + 2^b)^2*nn - q^2*nn for the bit under test
  logic [RW-1:0]         rem_r [NS-1];
  logic [RW-1:0]         x_r   [NS-1];
  logic [RW-1:0]         n_r   [NS-2];
  logic [RW-1:0]         n3_r  [NS-2];
  logic [ppd_pkg::QW-1:0] q_r  [NS];
  ppd_pkg::ctl_t         c_r   [NS];

  logic sat;

  genvar k;
  for (k = 0; k < NS; k++) begin : g_st
    localparam int B = CW - k;

    logic [RW-1:0]          rem_i;
    logic [RW-1:0]          x_i;
    logic [ppd_pkg::QW-1:0] q_i;
    ppd_pkg::ctl_t          c_i;
    logic [RW:0]            diff;
    logic                   acc;

    if (k == 0) begin : g_first
      assign rem_i = rem_in;
      assign x_i   = nn_in << (2 * CW);
      assign q_i   = '0;
      assign c_i   = ctl_in;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign x_i   = x_r[k-1];
      assign q_i   = q_r[k-1];
      assign c_i   = c_r[k-1];
    end

    assign diff = {1'b0, rem_i} - {1'b0, x_i};
    assign acc  = !diff[RW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_r[k] <= '0;
      end else if (en) begin
        c_r[k] <= c_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_i | (ppd_pkg::QW'(acc) << B);
      end
    end

    if (k < NS - 1) begin : g_upd
      logic [RW-1:0] n_i;
      logic [RW-1:0] n3_i;
      logic [RW-1:0] xh;

      if (k == 0) begin : g_n0
        assign n_i  = nn_in;
        assign n3_i = nn3_in;
      end else begin : g_nk
        assign n_i  = n_r[k-1];
        assign n3_i = n3_r[k-1];
      end

      assign xh = x_i >> 1;

      // next increment: x/2 + 3*2^(2b-2)*nn on accept, x/2 - 2^(2b-2)*nn otherwise
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= acc ? diff[RW-1:0] : rem_i;
          x_r[k]   <= acc ? xh + (n3_i << (2 * B - 2)) : xh - (n_i << (2 * B - 2));
        end
      end

      if (k < NS - 2) begin : g_fwd
        always_ff @(posedge clk) begin
          if (en) begin
            n_r[k]  <= n_i;
            n3_r[k] <= n3_i;
          end
        end
      end
    end
  end

  assign sat                 = q_r[NS-1][CW];
  assign out_vld             = c_r[NS-1].vld;
  assign out_word.degenerate = c_r[NS-1].degen;
  assign out_word.saturated  = sat && !c_r[NS-1].degen;
  assign out_word.distance   = c_r[NS-1].degen ? '0 :
                               sat ? '1 : q_r[NS-1][CW-1:0];

endmodule

>>> design/point_plane_distance.sv
// Point-to-plane distance, top level: differences, cross product, dot and norm
// products, squaring, then the quotient stages. Uses ppd_pkg, ppd_in_if,
// ppd_out_if, ppd_mul and ppd_root.
//
// Usage:
//   in_ch carries three plane points and a query point, signed Q16.16 each.
//   out_ch returns the unsigned Q16.16 distance floor(|a.n| / |n|) with
//   n = (p1-p3) x (p2-p3) and a = p3 - query, plus two flags: degenerate when
//   the plane points are collinear (distance 0), saturated when the distance
//   does not fit in 32 bits (distance all ones).
//   Both channels use valid/ready; a word moves when both are high.
// Timing:
//   One word per cycle is accepted unless the receiver stalls; a word passes
//   the difference, cross product and sign registers, two multiplier trees,
//   the sum and |dot| registers, and 33 quotient stages to out_ch.valid.
// Reset and stall:
//   rst_n (synchronous, active low) clears every valid bit; words in flight
//   are dropped. When the receiver holds ready low with a result waiting, the
//   whole pipeline holds and in_ch.ready falls; nothing is lost or repeated.
module point_plane_distance (
  input  logic      clk,
  input  logic      rst_n,
  ppd_in_if.sink    in_ch,
  ppd_out_if.source out_ch
);

  localparam int CW = ppd_pkg::CW;
  localparam int DW = ppd_pkg::DW;
  localparam int PW = ppd_pkg::PW;
  localparam int NW = ppd_pkg::NW;
  localparam int MW = ppd_pkg::MW;
  localparam int RW = ppd_pkg::RW;
  localparam int ML = ppd_pkg::ML;

  logic en;

  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [CW-1:0] pq [3];

  // stage A: differences
  logic                 va_r;
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] a_r [3];
  // stage B: cross product terms
  logic                 vb_r;
  logic signed [PW-1:0] pr_r [6];
  logic signed [DW-1:0] ab_r [3];
  // stage C: normal magnitudes and product signs
  logic                 vc_r;
  logic                 dc_r;
  logic signed [NW-1:0] nv [3];
  logic [PW-1:0]        nabs_r [3];
  logic [DW-1:0]        aabs_r [3];
  logic [2:0]           sg_r;
  // aligned with the first multipliers
  logic [ML-1:0]        vm_r;
  logic [ML-1:0]        dm_r;
  logic [2:0]           sm_r [ML];
  logic [RW-1:0]        sq_p [3];
  logic [RW-1:0]        an_p [3];
  // stage E: sums
  logic                 ve_r;
  logic                 de_r;
  logic [RW-1:0]        nn_r;
  logic [MW-1:0]        dot_r;
  logic [MW-1:0]        term [3];
  // stage F: |dot| and 3*nn
  logic                 vf_r;
  logic                 df_r;
  logic [MW-1:0]        dabs_r;
  logic [RW-1:0]        nf_r;
  logic [RW-1:0]        n3f_r;
  // aligned with the squaring multiplier
  logic [ML-1:0]        vd_r;
  logic [ML-1:0]        dd_r;
  logic [RW-1:0]        nd_r  [ML];
  logic [RW-1:0]        n3d_r [ML];
  logic [RW-1:0]        dsq_p;

  ppd_pkg::ctl_t        root_ctl;
  logic                 root_vld;
  ppd_pkg::out_word_t   root_word;

  // advance everything unless a result is waiting on a stalled receiver
  assign en          = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  assign p1[0] = in_ch.data.first_x;
  assign p1[1] = in_ch.data.first_y;
  assign p1[2] = in_ch.data.first_z;
  assign p2[0] = in_ch.data.second_x;
  assign p2[1] = in_ch.data.second_y;
  assign p2[2] = in_ch.data.second_z;
  assign p3[0] = in_ch.data.third_x;
  assign p3[1] = in_ch.data.third_y;
  assign p3[2] = in_ch.data.third_z;
  assign pq[0] = in_ch.data.query_x;
  assign pq[1] = in_ch.data.query_y;
  assign pq[2] = in_ch.data.query_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vm_r <= '0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vd_r <= '0;
    end else if (en) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vm_r <= {vm_r[ML-2:0], vc_r};
      ve_r <= vm_r[ML-1];
      vf_r <= ve_r;
      vd_r <= {vd_r[ML-2:0], vf_r};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = NW'(pr_r[2*i]) - NW'(pr_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i]    <= DW'(p1[i]) - DW'(p3[i]);
        v_r[i]    <= DW'(p2[i]) - DW'(p3[i]);
        a_r[i]    <= DW'(p3[i]) - DW'(pq[i]);
        ab_r[i]   <= a_r[i];
        nabs_r[i] <= nv[i][NW-1] ? PW'(-nv[i]) : PW'(nv[i]);
        aabs_r[i] <= ab_r[i][DW-1] ? DW'(-ab_r[i]) : DW'(ab_r[i]);
        sg_r[i]   <= nv[i][NW-1] ^ ab_r[i][DW-1];
      end
      pr_r[0] <= u_r[1] * v_r[2];
      pr_r[1] <= v_r[1] * u_r[2];
      pr_r[2] <= v_r[0] * u_r[2];
      pr_r[3] <= u_r[0] * v_r[2];
      pr_r[4] <= u_r[0] * v_r[1];
      pr_r[5] <= u_r[1] * v_r[0];
      dc_r    <= (nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0);
      dm_r    <= {dm_r[ML-2:0], dc_r};
      sm_r[0] <= sg_r;
      for (int s = 1; s < ML; s++) begin
        sm_r[s] <= sm_r[s-1];
      end
    end
  end

  genvar g;
  for (g = 0; g < 3; g++) begin : g_mul
    ppd_mul u_sq (
      .clk (clk),
      .en  (en),
      .a   (MW'(nabs_r[g])),
      .b   (MW'(nabs_r[g])),
      .p   (sq_p[g])
    );
    ppd_mul u_an (
      .clk (clk),
      .en  (en),
      .a   (MW'(aabs_r[g])),
      .b   (MW'(nabs_r[g])),
      .p   (an_p[g])
    );
    // apply the product sign in two's complement
    assign term[g] = sm_r[ML-1][g] ? ~an_p[g][MW-1:0] + 1'b1 : an_p[g][MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r   <= sq_p[0] + sq_p[1] + sq_p[2];
      dot_r  <= term[0] + term[1] + term[2];
      de_r   <= dm_r[ML-1];
      dabs_r <= dot_r[MW-1] ? ~dot_r + 1'b1 : dot_r;
      nf_r   <= nn_r;
      n3f_r  <= nn_r + (nn_r << 1);
      df_r   <= de_r;
      dd_r   <= {dd_r[ML-2:0], df_r};
      nd_r[0]  <= nf_r;
      n3d_r[0] <= n3f_r;
      for (int s = 1; s < ML; s++) begin
        nd_r[s]  <= nd_r[s-1];
        n3d_r[s] <= n3d_r[s-1];
      end
    end
  end

  ppd_mul u_dsq (
    .clk (clk),
    .en  (en),
    .a   (dabs_r),
    .b   (dabs_r),
    .p   (dsq_p)
  );

  assign root_ctl.vld   = vd_r[ML-1];
  assign root_ctl.degen = dd_r[ML-1];

  ppd_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (root_ctl),
    .rem_in   (dsq_p),
    .nn_in    (nd_r[ML-1]),
    .nn3_in   (n3d_r[ML-1]),
    .out_vld  (root_vld),
    .out_word (root_word)
  );

  assign out_ch.valid = root_vld;
  assign out_ch.data  = root_word;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.degenerate |->
      (out_ch.data.distance == '0) && !out_ch.data.saturated)
    else $error("degenerate word with nonzero distance or saturation");

  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.saturated |-> (out_ch.data.distance == '1))
    else $error("saturated word without full-scale distance");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output is stalled");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vd_r) && $stable(vm_r))
    else $error("pipeline valid bits moved during a stall");

endmodule

>>> dv/tb_chan_if.sv
`timescale 1ns / 1ps
// Testbench-side types: the expected-result record shared by the predictor
// and the checker. Depends on ppd_pkg for the coordinate width.
package tb_ppd_pkg;
  typedef struct {
    logic [ppd_pkg::CW-1:0] distance;
    logic                   degenerate;
    logic                   saturated;
  } dist_result_t;
endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Streams point/plane words into point_plane_distance and checks each result
// against an exact distance computed here. Uses ppd_pkg, tb_ppd_pkg, ppd_in_if, ppd_out_if.
module tb_top;

  logic clk = 0;
  logic rst_n = 0;
  int   errors = 0;
  int   idle_pct = 31;
  bit   hold_off = 0;
  int   quiet_cycles = 0;
  tb_ppd_pkg::dist_result_t dist_q[$];

  ppd_in_if  in_ch();
  ppd_out_if out_ch();

  point_plane_distance uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Exact distance: floor(|a.n|/|n|) by bitwise search on q^2*nn <= dd.
  function automatic tb_ppd_pkg::dist_result_t plane_distance(ppd_pkg::in_word_t w);
    tb_ppd_pkg::dist_result_t r;
    logic signed [39:0] ux, uy, uz, vx, vy, vz, ax, ay, az;
    logic signed [89:0] nx, ny, nz;
    logic signed [159:0] dot;
    logic [199:0] nn, dd, lim;
    logic [32:0] q;
    ux = 40'(w.first_x) - 40'(w.third_x);
    uy = 40'(w.first_y) - 40'(w.third_y);
    uz = 40'(w.first_z) - 40'(w.third_z);
    vx = 40'(w.second_x) - 40'(w.third_x);
    vy = 40'(w.second_y) - 40'(w.third_y);
    vz = 40'(w.second_z) - 40'(w.third_z);
    ax = 40'(w.third_x) - 40'(w.query_x);
    ay = 40'(w.third_y) - 40'(w.query_y);
    az = 40'(w.third_z) - 40'(w.query_z);
    nx = 90'(uy) * 90'(vz) - 90'(vy) * 90'(uz);
    ny = 90'(vx) * 90'(uz) - 90'(ux) * 90'(vz);
    nz = 90'(ux) * 90'(vy) - 90'(uy) * 90'(vx);
    nn = 200'($unsigned(160'(nx) * 160'(nx))) + 200'($unsigned(160'(ny) * 160'(ny)))
       + 200'($unsigned(160'(nz) * 160'(nz)));
    r.distance = '0; r.degenerate = 0; r.saturated = 0;
    if (nn == 0) begin
      r.degenerate = 1;
      return r;
    end
    dot = 160'(ax) * 160'(nx) + 160'(ay) * 160'(ny) + 160'(az) * 160'(nz);
    if (dot < 0) dot = -dot;
    dd = 200'(dot) * 200'(dot);
    lim = nn << 64;
    if (lim <= dd) begin
      r.distance = '1; r.saturated = 1;
      return r;
    end
    q = 0;
    for (int b = ppd_pkg::CW - 1; b >= 0; b--) begin
      q[b] = 1;
      if (200'(q) * 200'(q) * nn > dd) q[b] = 0;
    end
    r.distance = q[ppd_pkg::CW-1:0];
    return r;
  endfunction

  // valid stays high between back-to-back words; drop it only while idling
  task automatic send_word(ppd_pkg::in_word_t w);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    dist_q.push_back(plane_distance(w));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(2047) - 1024;
      2: return {$urandom} >> $urandom_range(31);
      default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
    endcase
  endfunction

  function automatic ppd_pkg::in_word_t rand_word();
    ppd_pkg::in_word_t w;
    int m;
    logic [31:0] c[12];
    m = $urandom_range(3);
    foreach (c[i]) c[i] = rand_coord($urandom_range(9) == 0 ? 3 : m);
    // collinear plane points now and then
    if ($urandom_range(15) == 0) begin
      c[3] = c[6] + 2 * (c[0] - c[6]);
      c[4] = c[7] + 2 * (c[1] - c[7]);
      c[5] = c[8] + 2 * (c[2] - c[8]);
    end
    w = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
    return w;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 0;
    @(negedge clk);
    while (dist_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    ppd_pkg::in_word_t w;
    // unit plane z=0, query at height 3.5
    w = '0; w.first_x = 32'h10000; w.second_y = 32'h10000; w.query_z = 32'h38000;
    send_word(w);
    w.query_z = -32'sh38000; send_word(w);
    w.query_z = 0; send_word(w);
    // coincident points
    w = '0; send_word(w);
    // collinear points
    w = '0; w.first_x = 1; w.second_x = 2; w.query_y = 5; send_word(w);
    // extremes: coordinates at the ends of the signed range
    w = '0; w.first_x = 1; w.second_y = 1; w.query_z = 32'h80000000; w.third_z = 32'h7fffffff;
    send_word(w);
    w = '1; send_word(w);
    w = {12{32'h80000000}}; w.first_x = 32'h7fffffff; w.second_y = 32'h7fffffff;
    send_word(w);
    w = {12{32'h7fffffff}}; w.first_x = 32'h80000000; w.second_y = 32'h80000000;
    w.query_z = 32'h80000000; send_word(w);
    w = {12{32'haaaaaaaa}}; w.first_x = 32'h55555555; w.second_z = 32'h55555555;
    send_word(w);
    for (int i = 0; i < 10; i++) send_word(rand_word());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      idle_pct = (i >= 300 && i < 450) ? 0 : 31;
      send_word(rand_word());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 120; i++) send_word(rand_word());
    // pause until all results have come
    wait_drained();
    for (int i = 0; i < 30; i++) send_word(rand_word());
  endtask

  // receiver: random stalls, plus a long hold-off stretch on request
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 0;
      repeat (200) @(negedge clk);
      hold_off = 0;
    end else
      out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    tb_ppd_pkg::dist_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dist_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_ch.data);
        errors++;
      end else begin
        e = dist_q.pop_front();
        if (out_ch.data.distance !== e.distance || out_ch.data.degenerate !== e.degenerate
            || out_ch.data.saturated !== e.saturated)
          begin
          $display("%0t mismatch exp d=%h g=%b s=%b act d=%h g=%b s=%b", $time,
                   e.distance, e.degenerate, e.saturated, out_ch.data.distance,
                   out_ch.data.degenerate, out_ch.data.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_backpressure();
    test_random(1000);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && dist_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
